[rtl/afr_pkg.sv]
// Shared constants, codes and types of the addressed frame receiver.
package afr_pkg;

    localparam int COMMAND_SLOTS = 4;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int CAUSE_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int WINDOW_DEPTH = 6;

    localparam logic [BYTE_W-1:0] SOH = 8'h01;
    localparam logic [BYTE_W-1:0] STX = 8'h02;
    localparam logic [BYTE_W-1:0] ETX = 8'h03;
    localparam logic [BYTE_W-1:0] EOT = 8'h04;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN_STATION = 3'd0;
    localparam int                   REG_SLOT_BASE   = 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } kind_t;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_NO_ETX   = 2'd1,
        CAUSE_CHECKSUM = 2'd2,
        CAUSE_NO_EOT   = 2'd3
    } cause_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] sender_station;
        logic [BYTE_W-1:0] command_code;
        logic [BYTE_W-1:0] payload_length;
        logic              dispatch;
        cause_t            reject_cause;
    } result_t;

endpackage

[rtl/afr_if.sv]
// Stream channels of the addressed frame receiver: received bytes and results.
interface afr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afr_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] sender_station;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic       dispatch;
    logic [1:0] reject_cause;

    modport source (output valid, output kind, output payload_byte, output sender_station,
                    output command_code, output payload_length, output dispatch,
                    output reject_cause, input ready);
    modport sink   (input valid, input kind, input payload_byte, input sender_station,
                    input command_code, input payload_length, input dispatch,
                    input reject_cause, output ready);
endinterface

[rtl/afr_cfg_regs.sv]
// Configuration registers: own station address and command slots with slot match.
module afr_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [afr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [afr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [afr_pkg::BYTE_W-1:0]    command,
    output logic [afr_pkg::BYTE_W-1:0]    own_station,
    output logic                          slot_hit
);
    import afr_pkg::*;

    logic [BYTE_W-1:0] own_station_reg;
    logic [BYTE_W-1:0] slot_reg [COMMAND_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_station_reg <= '0;
            for (int i = 0; i < COMMAND_SLOTS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            // Indexes beyond the register list fall through and are dropped
            if (cfg_index == REG_OWN_STATION)
            begin
                own_station_reg <= cfg_wdata[BYTE_W-1:0];
            end
            for (int i = 0; i < COMMAND_SLOTS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(REG_SLOT_BASE + i))
                begin
                    slot_reg[i] <= cfg_wdata[BYTE_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        slot_hit = 1'b0;
        for (int i = 0; i < COMMAND_SLOTS; i++)
        begin
            if (slot_reg[i] != '0 && slot_reg[i] == command)
            begin
                slot_hit = 1'b1;
            end
        end
    end

    assign own_station = own_station_reg;

`ifndef ASSERT_OFF
    a_empty_slot_never_hits: assert property (@(posedge clk) disable iff (!rst_n)
        command == '0 |-> !slot_hit)
        else $error("slot match reported for command zero");

    a_station_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_OWN_STATION
        |=> own_station == $past(cfg_wdata[BYTE_W-1:0]))
        else $error("own station write did not land");

    a_stray_index_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index > CFG_IDX_W'(REG_SLOT_BASE + COMMAND_SLOTS - 1)
        |=> $stable(own_station))
        else $error("write to an unknown index changed the own station");
`endif

endmodule

[rtl/addressed_frame_receiver_top.sv]
// Top level of the addressed frame receiver: header hunt, frame sequencer, result register.
//
//   channel   | dir | payload                                              | transfer
//   ----------+-----+------------------------------------------------------+-----------------
//   in_ch     | in  | rx_byte                                              | valid & ready
//   out_ch    | out | kind, payload_byte, sender_station, command_code,    | valid & ready
//             |     | payload_length, dispatch, reject_cause               |
//   cfg port  | in  | cfg_index, cfg_wdata                                 | cfg_we
//
// One byte per cycle unless a held result stalls: each accepted byte updates the frame
// state and, when it causes a result, loads the result register, shown the next cycle.
// The critical path is the 4-byte checksum seed add on header match.
// Reset clears the header window, frame state and result valid; no clearing pass.
// A stalled result holds; a new byte is still taken in the cycle the result is taken.
module addressed_frame_receiver_top (
    input  logic                           clk,
    input  logic                           rst_n,
    afr_byte_if.sink                       in_ch,
    afr_result_if.source                   out_ch,
    input  logic                           cfg_we,
    input  logic [afr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import afr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT     = 3'd0,
        PH_PAYLOAD  = 3'd1,
        PH_ETX      = 3'd2,
        PH_CHECKSUM = 3'd3,
        PH_EOT      = 3'd4
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] window_reg [WINDOW_DEPTH];
    logic [BYTE_W-1:0] window_next [WINDOW_DEPTH];
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] sender_reg, sender_next;
    logic [BYTE_W-1:0] command_reg, command_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;

    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic              in_accept;
    logic              emit;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] own_station;
    logic              slot_hit;
    logic [BYTE_W-1:0] count_inc;

    afr_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .command     (command_reg),
        .own_station (own_station),
        .slot_hit    (slot_hit)
    );

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign b           = in_ch.rx_byte;
    assign count_inc   = count_reg + 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        window_next  = window_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        sender_next  = sender_reg;
        command_next = command_reg;
        sum_next     = sum_reg;
        emit         = 1'b0;

        out_next.kind           = KIND_PAYLOAD;
        out_next.payload_byte   = '0;
        out_next.sender_station = sender_reg;
        out_next.command_code   = command_reg;
        out_next.payload_length = length_reg;
        out_next.dispatch       = 1'b0;
        out_next.reject_cause   = CAUSE_NONE;

        case (phase_reg)
            PH_PAYLOAD:
            begin
                sum_next              = sum_reg + b;
                count_next            = count_inc;
                emit                  = 1'b1;
                out_next.payload_byte = b;
                if (count_inc == length_reg)
                begin
                    phase_next = PH_ETX;
                end
            end
            PH_ETX:
            begin
                if (b == ETX)
                begin
                    phase_next = PH_CHECKSUM;
                end
                else
                begin
                    emit                  = 1'b1;
                    out_next.kind         = KIND_REJECT;
                    out_next.reject_cause = CAUSE_NO_ETX;
                end
            end
            PH_CHECKSUM:
            begin
                if (b == sum_reg)
                begin
                    phase_next = PH_EOT;
                end
                else
                begin
                    emit                  = 1'b1;
                    out_next.kind         = KIND_REJECT;
                    out_next.reject_cause = CAUSE_CHECKSUM;
                end
            end
            PH_EOT:
            begin
                emit = 1'b1;
                if (b == EOT)
                begin
                    out_next.kind     = KIND_ACCEPT;
                    out_next.dispatch = slot_hit;
                end
                else
                begin
                    out_next.kind         = KIND_REJECT;
                    out_next.reject_cause = CAUSE_NO_EOT;
                end
            end
            default:
            begin
                // Shift the byte into the header window and look for a header
                for (int i = 0; i < WINDOW_DEPTH - 1; i++)
                begin
                    window_next[i] = window_reg[i+1];
                end
                window_next[WINDOW_DEPTH-1] = b;
                phase_next = PH_HUNT;
                if (window_reg[1] == SOH && b == STX && window_reg[2] == own_station)
                begin
                    sender_next  = window_reg[3];
                    command_next = window_reg[4];
                    length_next  = window_reg[5];
                    count_next   = '0;
                    sum_next     = window_reg[2] + window_reg[3]
                                 + window_reg[4] + window_reg[5];
                    phase_next   = (window_reg[5] == '0) ? PH_ETX : PH_PAYLOAD;
                end
            end
        endcase

        // The end of a frame, good or bad, drops the frame state
        if (phase_reg == PH_ETX || phase_reg == PH_CHECKSUM || phase_reg == PH_EOT)
        begin
            if (emit)
            begin
                phase_next   = PH_HUNT;
                length_next  = '0;
                count_next   = '0;
                sender_next  = '0;
                command_next = '0;
                sum_next     = '0;
            end
        end

        if (in_accept)
        begin
            out_valid_next = emit || (out_valid_reg && !out_ch.ready);
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ch.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            length_reg    <= '0;
            count_reg     <= '0;
            sender_reg    <= '0;
            command_reg   <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                phase_reg   <= phase_next;
                window_reg  <= window_next;
                length_reg  <= length_next;
                count_reg   <= count_next;
                sender_reg  <= sender_next;
                command_reg <= command_next;
                sum_reg     <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.kind           = out_reg.kind;
    assign out_ch.payload_byte   = out_reg.payload_byte;
    assign out_ch.sender_station = out_reg.sender_station;
    assign out_ch.command_code   = out_reg.command_code;
    assign out_ch.payload_length = out_reg.payload_length;
    assign out_ch.dispatch       = out_reg.dispatch;
    assign out_ch.reject_cause   = out_reg.reject_cause;

`ifndef ASSERT_OFF
    a_payload_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && phase_reg == PH_PAYLOAD
        |=> out_valid_reg && out_reg.kind == KIND_PAYLOAD)
        else $error("payload byte accepted without a payload result");

    a_cause_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.kind == KIND_REJECT) == (out_reg.reject_cause != CAUSE_NONE)))
        else $error("reject cause disagrees with result kind");

    a_dispatch_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.dispatch |-> out_reg.kind == KIND_ACCEPT)
        else $error("dispatch flagged on a result that is not an accepted frame");

    a_count_below_length: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> count_reg < length_reg)
        else $error("payload count reached the frame length while still in payload");
`endif

endmodule
